FILE: hw/rtl/rgbls_pkg.sv
// Shared types and constants of the RGB LED grayscale scan serializer.
`timescale 1ns / 1ps
`default_nettype none

package rgbls_pkg;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_BIT    = 2'd1,
    KIND_PERIOD = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    COLOUR_RED   = 2'd0,
    COLOUR_GREEN = 2'd1,
    COLOUR_BLUE  = 2'd2
  } colour_t;

  localparam logic [1:0] FET_OFF = 2'd0;
  localparam logic [1:0] CHANNEL_NONE = 2'd3;
  localparam int DATA_BITS = 8;

  typedef struct packed {
    logic       shift;
    logic       pad;
    logic [2:0] bit_sel;
    logic       sclk;
    logic       xlat;
    logic       blank;
    logic [1:0] fet;
    logic       done;
  } stage_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rgb_led_grayscale_scan_serializer.sv
// Top level of the RGB LED grayscale scan serializer with its pixel store.
//
// Channel  Dir  Handshake          Payload
// s        in   s_tvalid/s_tready  s_tuser kind, s_tdata write fields
// m        out  m_tvalid/m_tready  m_tdata line levels and FET, m_tlast frame done
//
// One item per cycle unless the output stalls; items pass read and output stages.
// A bit tick reads one byte of the pixel store, whose read port is registered.
// After reset the store is cleared one entry per cycle, all 3*ROWS*COLS entries
// (384 by default), and s_tready stays low until the pass is over.
// A stalled output holds one result while the next item waits in the read stage.
`timescale 1ns / 1ps
`default_nettype none

module rgb_led_grayscale_scan_serializer #(
  parameter int ROWS     = 8,
  parameter int COLS     = 16,
  parameter int PAD_BITS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  // wr_row [2:0], wr_col [6:3], wr_channel [8:7], wr_value [16:9]
  input  wire logic [23:0] s_tdata,
  // kind [1:0]
  input  wire logic [1:0]  s_tuser,
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  // sin_level [0], sclk_pulse [1], xlat_pulse [2], blank_pulse [3], fet_select [5:4]
  output      logic [7:0]  m_tdata,
  output      logic        m_tlast
);
  import rgbls_pkg::*;

  localparam int NPIX   = ROWS * COLS;
  localparam int DEPTH  = NPIX * 3;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = (NPIX > 1) ? $clog2(NPIX) : 1;
  localparam int BPP    = PAD_BITS + DATA_BITS;
  localparam int PH_W   = $clog2(BPP + 2);

  logic [DATA_BITS-1:0] mem [DEPTH];
  logic [DATA_BITS-1:0] rd_data;

  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  colour_t          send_colour, send_colour_next;
  logic [1:0]       lit_fet, lit_fet_next;
  logic             latch_pending, latch_pending_next;
  logic             extra_clock_due, extra_clock_due_next;
  logic [IDX_W-1:0] channel_index, channel_index_next;
  logic [PH_W-1:0]  bit_phase, bit_phase_next;

  logic        s1_valid;
  stage_t      s1, s1_next;
  logic        out_sin;
  logic        sin_new;
  logic [1:0]  out_fet;
  logic        out_sclk, out_xlat, out_blank, out_done;

  logic        accept;
  logic        advance;
  kind_t       kind;
  logic [2:0]  wr_row;
  logic [3:0]  wr_col;
  logic [1:0]  wr_channel;
  logic [7:0]  wr_value;
  logic        wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  logic [PH_W-1:0] phase_a;
  logic [PH_W-1:0] pos;
  logic [PH_W-1:0] pos_data;

  assign kind       = kind_t'(s_tuser);
  assign wr_row     = s_tdata[2:0];
  assign wr_col     = s_tdata[6:3];
  assign wr_channel = s_tdata[8:7];
  assign wr_value   = s_tdata[16:9];

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !clearing && (!s1_valid || advance);
  assign accept   = s_tvalid && s_tready;

  assign wr_en = accept && (kind == KIND_WRITE) && ({4'b0, wr_row} < 7'(ROWS)) &&
                 ({3'b0, wr_col} < 7'(COLS)) && (wr_channel != CHANNEL_NONE);
  assign wr_addr = (ADDR_W'(wr_row) * ADDR_W'(COLS) + ADDR_W'(wr_col)) * ADDR_W'(3) +
                   ADDR_W'(wr_channel);
  assign rd_addr = ADDR_W'({channel_index, 1'b0}) + ADDR_W'(channel_index) +
                   ADDR_W'(send_colour);

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_value;
    end
    if (accept) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  assign phase_a  = (bit_phase == '0) ? PH_W'(1) : bit_phase;
  assign pos      = phase_a - PH_W'(1);
  assign pos_data = pos - PH_W'(PAD_BITS);

  always_comb begin
    send_colour_next     = send_colour;
    lit_fet_next         = lit_fet;
    latch_pending_next   = latch_pending;
    extra_clock_due_next = extra_clock_due;
    channel_index_next   = channel_index;
    bit_phase_next       = bit_phase;
    s1_next              = '0;
    s1_next.pad          = (pos < PH_W'(PAD_BITS));
    s1_next.bit_sel      = pos_data[2:0];
    unique case (kind)
      KIND_WRITE: begin
      end
      KIND_BIT: begin
        if (!latch_pending) begin
          s1_next.sclk  = 1'b1;
          s1_next.shift = 1'b1;
          if (bit_phase == '0) begin
            bit_phase_next = PH_W'(1);
            if (extra_clock_due) begin
              s1_next.shift = 1'b0;
            end else begin
              extra_clock_due_next = 1'b1;
            end
          end
          if (s1_next.shift) begin
            if (phase_a == PH_W'(BPP)) begin
              bit_phase_next = PH_W'(1);
              if (channel_index == IDX_W'(NPIX - 1)) begin
                channel_index_next = '0;
                bit_phase_next     = '0;
                latch_pending_next = 1'b1;
                s1_next.done       = 1'b1;
              end else begin
                channel_index_next = channel_index + 1'b1;
              end
            end else begin
              bit_phase_next = phase_a + PH_W'(1);
            end
          end
        end
      end
      KIND_PERIOD: begin
        s1_next.blank = 1'b1;
        if (latch_pending) begin
          s1_next.xlat       = 1'b1;
          latch_pending_next = 1'b0;
          lit_fet_next       = 2'(send_colour) + 2'd1;
          unique case (send_colour)
            COLOUR_RED:   send_colour_next = COLOUR_GREEN;
            COLOUR_GREEN: send_colour_next = COLOUR_BLUE;
            default:      send_colour_next = COLOUR_RED;
          endcase
        end
      end
      default: begin
      end
    endcase
    s1_next.fet = lit_fet_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      send_colour     <= COLOUR_RED;
      lit_fet         <= FET_OFF;
      latch_pending   <= 1'b0;
      extra_clock_due <= 1'b0;
      channel_index   <= '0;
      bit_phase       <= '0;
    end else if (accept) begin
      send_colour     <= send_colour_next;
      lit_fet         <= lit_fet_next;
      latch_pending   <= latch_pending_next;
      extra_clock_due <= extra_clock_due_next;
      channel_index   <= channel_index_next;
      bit_phase       <= bit_phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1 <= s1_next;
    end
  end

  assign sin_new = s1.shift ? (!s1.pad && rd_data[3'd7 - s1.bit_sel]) : out_sin;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      out_sin  <= 1'b0;
    end else if (advance) begin
      m_tvalid <= s1_valid;
      if (s1_valid) begin
        out_sin <= sin_new;
      end
    end
    if (advance && s1_valid) begin
      out_sclk  <= s1.sclk;
      out_xlat  <= s1.xlat;
      out_blank <= s1.blank;
      out_fet   <= s1.fet;
      out_done  <= s1.done;
    end
  end

  assign m_tdata = {2'b00, out_fet, out_blank, out_xlat, out_sclk, out_sin};
  assign m_tlast = out_done;

endmodule

`default_nettype wire

FILE: hw/rtl/rgbls_checker.sv
// Port checker of the RGB LED grayscale scan serializer and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module rgbls_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [7:0]  m_tdata,
  input wire logic        m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("Stalled output item changed.");

  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !s_tready && !m_tvalid)
    else $error("Item traffic right after reset.");

  a_done_is_shift: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[1] && !m_tdata[3] && !m_tdata[2])
    else $error("Frame end without a serial clock.");

  a_latch_blank: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[3] && !m_tdata[1] && (m_tdata[5:4] != 2'd0))
    else $error("Latch without blank or lit FET.");

endmodule

bind rgb_led_grayscale_scan_serializer rgbls_checker u_rgbls_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the RGB LED grayscale scan serializer with a scoreboard class.
`timescale 1ns / 1ps

module testbench;
  import rgbls_pkg::*;

  localparam int ROWS = 8;
  localparam int COLS = 16;
  localparam int PAD_BITS = 4;
  localparam int NPIX = ROWS * COLS;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int LIMIT = 1000000;
  localparam int ITEMS = 400;

  typedef struct packed {
    logic       sin;
    logic       sclk;
    logic       xlat;
    logic       blank;
    logic [1:0] fet;
    logic       done;
  } levels_t;

  class led_scan_model;
    logic [7:0]  pixels [NPIX * 3];
    colour_t     colour;
    logic [1:0]  fet;
    bit          latch_due;
    bit          extra_due;
    int unsigned chan;
    int unsigned phase;
    logic        sin_held;
    levels_t     expected_levels [$];
    int          errors;
    int          writes;
    int          bit_ticks;
    int          period_ticks;
    int          frames;
    int          results;

    function new();
      foreach (pixels[i]) pixels[i] = 8'd0;
      colour = COLOUR_RED;
      fet = FET_OFF;
      latch_due = 0;
      extra_due = 0;
      chan = 0;
      phase = 0;
      sin_held = 1'b0;
      errors = 0;
      writes = 0;
      bit_ticks = 0;
      period_ticks = 0;
      frames = 0;
      results = 0;
    endfunction

    function void report(string what, int unsigned got, int unsigned want);
      errors++;
      if (errors <= 100)
        $display("%0t: mismatch in %s after %0d results: got %0h, expected %0h",
                 $time, what, results, got, want);
    endfunction

    function void check_field(string what, int unsigned got, int unsigned want);
      if (got != want) report(what, got, want);
    endfunction

    function void note_item(logic [1:0] kind, logic [23:0] data);
      levels_t     r;
      int unsigned row;
      int unsigned col;
      int unsigned ch;
      int unsigned pos;
      bit          shift;
      logic [7:0]  v;
      r = '0;
      case (kind)
        KIND_WRITE: begin
          row = data[2:0];
          col = data[6:3];
          ch = data[8:7];
          writes++;
          if (row < ROWS && col < COLS && ch < 3)
            pixels[(row * COLS + col) * 3 + ch] = data[16:9];
        end
        KIND_BIT: begin
          bit_ticks++;
          if (!latch_due) begin
            shift = 1;
            if (phase == 0) begin
              phase = 1;
              if (extra_due) begin
                r.sclk = 1'b1;
                shift = 0;
              end else begin
                extra_due = 1;
              end
            end
            if (shift) begin
              pos = phase - 1;
              if (pos < PAD_BITS) begin
                sin_held = 1'b0;
              end else begin
                v = pixels[chan * 3 + colour];
                sin_held = v[7 - (pos - PAD_BITS)];
              end
              r.sclk = 1'b1;
              phase++;
              if (phase > PAD_BITS + DATA_BITS) begin
                phase = 1;
                chan++;
                if (chan >= NPIX) begin
                  chan = 0;
                  phase = 0;
                  latch_due = 1;
                  r.done = 1'b1;
                end
              end
            end
          end
        end
        KIND_PERIOD: begin
          period_ticks++;
          r.blank = 1'b1;
          if (latch_due) begin
            r.xlat = 1'b1;
            latch_due = 0;
            frames++;
            fet = colour + 2'd1;
            colour = (colour == COLOUR_BLUE) ? COLOUR_RED : colour_t'(colour + 2'd1);
          end
        end
        default: ;
      endcase
      r.sin = sin_held;
      r.fet = fet;
      expected_levels.push_back(r);
    endfunction

    function void check_levels(logic [7:0] data, logic last);
      levels_t want;
      if (expected_levels.size() == 0) begin
        report("unexpected result", {last, data}, 0);
        return;
      end
      want = expected_levels.pop_front();
      results++;
      check_field("sin_level", data[0], want.sin);
      check_field("sclk_pulse", data[1], want.sclk);
      check_field("xlat_pulse", data[2], want.xlat);
      check_field("blank_pulse", data[3], want.blank);
      check_field("fet_select", data[5:4], want.fet);
      check_field("frame_done", last, want.done);
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  led_scan_model model = new();
  int          cycles = 0;
  int          items_sent = 0;
  bit          sender_idle = 0;
  bit          receiver_idle = 0;

  rgb_led_grayscale_scan_serializer #(
    .ROWS(ROWS),
    .COLS(COLS),
    .PAD_BITS(PAD_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [23:0] pack_write(int unsigned row, int unsigned col,
                                             int unsigned ch, int unsigned value);
    logic [23:0] d;
    d = '0;
    d[2:0] = row[2:0];
    d[6:3] = col[3:0];
    d[8:7] = ch[1:0];
    d[16:9] = value[7:0];
    return d;
  endfunction

  function automatic logic [23:0] rand_write();
    return pack_write($urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 3),
                      $urandom_range(0, 255));
  endfunction

  task automatic send_item(input logic [1:0] kind, input logic [23:0] data);
    int gap;
    if (items_sent % 200 == 0) sender_idle = ($urandom_range(0, 3) != 0);
    gap = sender_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    model.note_item(kind, data);
    items_sent++;
  endtask

  task automatic run_frame();
    int pick;
    while (!model.latch_due && items_sent < ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)
        send_item(KIND_WRITE, pack_write(model.chan / COLS, model.chan % COLS, model.colour,
                                         $urandom_range(0, 255)));
      else if (pick < 10)
        send_item(KIND_WRITE, rand_write());
      else if (pick < 12)
        send_item(KIND_PERIOD, rand_write());
      else if (pick < 13)
        send_item(KIND_UNUSED, rand_write());
      else
        send_item(KIND_BIT, rand_write());
    end
    repeat ($urandom_range(0, 3)) send_item(KIND_BIT, '0);
    send_item(KIND_PERIOD, '0);
  endtask

  // Receiver: random stalls per result, plus one long hold-off to back up the pipeline.
  initial begin
    int stall;
    int taken;
    taken = 0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (taken % 200 == 0) receiver_idle = ($urandom_range(0, 3) != 0);
      stall = receiver_idle ? $urandom_range(0, 14) : 0;
      if (taken == 120) stall = 400;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      model.check_levels(m_tdata, m_tlast);
      taken++;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_item(KIND_PERIOD, '0);
    send_item(KIND_UNUSED, 24'h01ffff);
    send_item(KIND_WRITE, pack_write(0, 0, COLOUR_RED, 255));
    send_item(KIND_WRITE, pack_write(0, 0, COLOUR_GREEN, 8'ha5));
    send_item(KIND_WRITE, pack_write(7, 15, COLOUR_BLUE, 8'h81));
    send_item(KIND_WRITE, pack_write(7, 15, CHANNEL_NONE, 255));
    send_item(KIND_WRITE, pack_write(3, 9, COLOUR_RED, 8'h7e));
    repeat (10) send_item(KIND_BIT, '0);
    send_item(KIND_WRITE, pack_write(0, 1, COLOUR_RED, 8'h80));
    send_item(KIND_PERIOD, '0);
    repeat (6) send_item(KIND_BIT, 24'h01ffff);

    repeat (150) begin
      if ($urandom_range(0, 4) != 0)
        send_item(KIND_WRITE, rand_write());
      else
        send_item(2'($urandom_range(0, 3)), rand_write());
    end
    run_frame();

    s_tvalid <= 1'b0;
    while (model.expected_levels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d items: %0d writes, %0d bit ticks, %0d period ticks.",
             items_sent, model.writes, model.bit_ticks, model.period_ticks);
    $display("Checked %0d results across %0d latched frames.", model.results, model.frames);
    if (model.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
